// ===== src/smw_pkg.sv =====
// Package for the screen melt wipe column block
// Holds the action codes, seed and step constants, and the mod-3 helper
// No dependencies
`timescale 1ns / 1ps
`default_nettype none

package smw_pkg;

  typedef enum logic {
    ACT_SEED    = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_e;

  localparam int SEED_FLOOR     = -16;
  localparam int SEED_FLOOR_FIX = -15;
  localparam int FAST_LIMIT     = 16;
  localparam int SLOW_STEP      = 8;

  // byte mod 3 by summing base-4 digits, since 4 is 1 mod 3
  function automatic logic [1:0] mod3(input logic [7:0] b);
    logic [3:0] s;
    logic [2:0] t;
    begin
      s = {2'b00, b[7:6]} + {2'b00, b[5:4]} + {2'b00, b[3:2]} + {2'b00, b[1:0]};
      t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
      if (t >= 3'd3) begin
        t = t - 3'd3;
      end
      mod3 = t[1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/screen_melt_wipe_columns.sv =====
// Screen melt wipe, per-column delay and melt position tracking
// Depends on smw_pkg and smw_ram
//
// Usage:
//   An item is offered on action_i, column_i and random_byte_i with start_i.
//   It is taken at a rising edge where start_i is high and busy_o is low;
//   busy_o stays low, so an item may be offered every cycle.
//   A seed item sets the start delay of a column, an advance item steps one
//   column by one frame. Each item gives one result, registered through stage 1
//   and the result registers, on the result ports for one cycle with valid_o high.
//   Throughput is one item per cycle. The column positions live in one RAM
//   with a registered read: the column is read into stage 1, then the result
//   is computed, written back and registered. A write to a column that the
//   following item reads is forwarded to it.
//   The receiver cannot stall; results must be taken when valid_o is high.
//   Reset clears the previous seed, the pass flag and the pipeline. Column
//   positions are not cleared: a column must be seeded before it advances.
//   Columns at or above COLUMNS change nothing and give a zero result.
`timescale 1ns / 1ps
`default_nettype none

module screen_melt_wipe_columns #(
  parameter int COLUMNS = 320,
  parameter int ROWS    = 200
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              action_i,
  input  wire logic [8:0]        column_i,
  input  wire logic [7:0]        random_byte_i,
  output logic                   valid_o,
  output logic      [8:0]        out_column_o,
  output logic signed [8:0]      column_offset_o,
  output logic                   drawn_o,
  output logic      [7:0]        new_rows_o,
  output logic                   moving_o,
  output logic                   frame_done_o
);

  localparam int AW = $clog2(COLUMNS);
  localparam int PW = $clog2(ROWS + smw_pkg::SLOW_STEP) + 1;
  localparam logic signed [PW-1:0] ROWS_P = PW'(ROWS);

  logic accept;

  // stage 1 registers
  logic                 s1_valid_q;
  smw_pkg::action_e     s1_action_q;
  logic [8:0]           s1_col_q;
  logic [7:0]           s1_rnd_q;
  logic                 s1_inr_q;
  logic                 s1_last_q;

  // forwarding of the write made by stage 1
  logic                 fwd_hit_q, fwd_hit_d;
  logic signed [PW-1:0] fwd_val_q;

  logic signed [4:0]    prev_seed_q, prev_seed_d;
  logic                 pass_moving_q, pass_moving_d;

  logic [PW-1:0]        rd_data;
  logic signed [PW-1:0] pos;
  logic signed [PW-1:0] new_pos;
  logic signed [PW-1:0] rows;
  logic signed [6:0]    seed_v;
  logic                 we;
  logic                 res_drawn, res_moving, res_done;

  // result registers
  logic                 valid_q;
  logic [8:0]           out_col_q;
  logic signed [8:0]    offset_q, offset_d;
  logic                 drawn_q, moving_q, done_q;
  logic [7:0]           rows_q, rows_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  smw_ram #(
    .WIDTH(PW),
    .DEPTH(COLUMNS)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(AW'(s1_col_q)),
    .wdata_i(new_pos),
    .re_i   (accept),
    .raddr_i(AW'(column_i)),
    .rdata_o(rd_data)
  );

  assign pos = fwd_hit_q ? fwd_val_q : signed'(rd_data);

  always_comb begin
    seed_v        = '0;
    new_pos       = pos;
    rows          = '0;
    res_drawn     = 1'b0;
    res_moving    = 1'b0;
    res_done      = 1'b0;
    we            = 1'b0;
    prev_seed_d   = prev_seed_q;
    pass_moving_d = pass_moving_q;
    offset_d      = '0;
    if (s1_valid_q && s1_inr_q) begin
      we = 1'b1;
      if (s1_action_q == smw_pkg::ACT_SEED) begin
        if (s1_col_q == 9'd0) begin
          seed_v = 7'sd0 - signed'({3'b000, s1_rnd_q[3:0]});
        end else begin
          seed_v = 7'(prev_seed_q) + signed'({5'b00000, smw_pkg::mod3(s1_rnd_q)}) - 7'sd1;
          if (seed_v > 7'sd0) begin
            seed_v = 7'sd0;
          end else if (seed_v == 7'(smw_pkg::SEED_FLOOR)) begin
            seed_v = 7'(smw_pkg::SEED_FLOOR_FIX);
          end
        end
        new_pos     = PW'(seed_v);
        prev_seed_d = 5'(seed_v);
        offset_d    = 9'(seed_v);
      end else begin
        if (pos < 0) begin
          new_pos    = pos + PW'(1);
          res_moving = 1'b1;
        end else if (pos < ROWS_P) begin
          if (pos < PW'(smw_pkg::FAST_LIMIT)) begin
            new_pos = pos + pos + PW'(1);
          end else begin
            new_pos = pos + PW'(smw_pkg::SLOW_STEP);
          end
          res_moving = 1'b1;
          res_drawn  = 1'b1;
          rows       = (new_pos > ROWS_P) ? ROWS_P : new_pos;
        end
        pass_moving_d = pass_moving_q | res_moving;
        if (s1_last_q) begin
          res_done      = !pass_moving_d;
          pass_moving_d = 1'b0;
        end
        offset_d = 9'(new_pos);
      end
    end
  end

  assign rows_d    = 8'(rows);
  assign fwd_hit_d = we && accept && (AW'(column_i) == AW'(s1_col_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      valid_q       <= 1'b0;
      fwd_hit_q     <= 1'b0;
      prev_seed_q   <= '0;
      pass_moving_q <= 1'b0;
    end else begin
      s1_valid_q    <= accept;
      valid_q       <= s1_valid_q;
      fwd_hit_q     <= fwd_hit_d;
      prev_seed_q   <= prev_seed_d;
      pass_moving_q <= pass_moving_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= smw_pkg::action_e'(action_i);
      s1_col_q    <= column_i;
      s1_rnd_q    <= random_byte_i;
      s1_inr_q    <= ({23'b0, column_i} < 32'(COLUMNS));
      s1_last_q   <= ({23'b0, column_i} == 32'(COLUMNS - 1));
    end
    fwd_val_q <= new_pos;
    out_col_q <= s1_col_q;
    offset_q  <= offset_d;
    drawn_q   <= res_drawn;
    rows_q    <= rows_d;
    moving_q  <= res_moving;
    done_q    <= res_done;
  end

  assign valid_o         = valid_q;
  assign out_column_o    = out_col_q;
  assign column_offset_o = offset_q;
  assign drawn_o         = drawn_q;
  assign new_rows_o      = rows_q;
  assign moving_o        = moving_q;
  assign frame_done_o    = done_q;

endmodule

`default_nettype wire

// ===== src/smw_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM
// Read data is registered; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module smw_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 320
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/smw_checker.sv =====
// Port-level checker for screen_melt_wipe_columns, bound to the top level
// Depends on the top level's ports only
`timescale 1ns / 1ps
`default_nettype none

module smw_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic              action_i,
  input wire logic [8:0]        column_i,
  input wire logic [7:0]        random_byte_i,
  input wire logic              valid_o,
  input wire logic [8:0]        out_column_o,
  input wire logic signed [8:0] column_offset_o,
  input wire logic              drawn_o,
  input wire logic [7:0]        new_rows_o,
  input wire logic              moving_o,
  input wire logic              frame_done_o
);

  // every accepted item gives its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 valid_o)
    else $error("item without result");

  // every result traces back to an item, for the same column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, 2) && out_column_o == $past(column_i, 2))
    else $error("result without item");

  // a drawn column is a moving one, an undrawn one shows no rows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!drawn_o || moving_o) && (drawn_o || new_rows_o == 8'd0))
    else $error("drawn and rows disagree");

  // end of pass cannot be reported by a moving column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && frame_done_o |-> !moving_o)
    else $error("frame done on a moving column");

endmodule

bind screen_melt_wipe_columns smw_checker u_smw_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for screen_melt_wipe_columns: seed and advance items with random idle gaps
// Results are checked against an in-bench column position predictor, in order
// Depends on smw_pkg and the screen_melt_wipe_columns RTL
`timescale 1ns / 1ps

module testbench;

  localparam int COLUMNS = 320;
  localparam int ROWS = 200;
  localparam int ITEM_TARGET = 1150;

  typedef struct {
    logic [8:0]        column;
    logic signed [8:0] offset;
    logic              drawn;
    logic [7:0]        rows;
    logic              moving;
    logic              done;
  } melt_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              action_i = 1'b0;
  logic [8:0]        column_i = '0;
  logic [7:0]        random_byte_i = '0;
  logic              valid_o;
  logic [8:0]        out_column_o;
  logic signed [8:0] column_offset_o;
  logic              drawn_o;
  logic [7:0]        new_rows_o;
  logic              moving_o;
  logic              frame_done_o;

  // predictor state
  int column_pos [COLUMNS];
  bit seeded [COLUMNS];
  int seed_prev = 0;
  bit pass_moved = 1'b0;

  melt_result_t pending_results[$];
  int items_sent = 0;
  int results_checked = 0;
  int drawn_seen = 0;
  int done_seen = 0;
  int errors = 0;
  bit gaps_enabled = 1'b1;

  screen_melt_wipe_columns #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .action_i(action_i),
    .column_i(column_i),
    .random_byte_i(random_byte_i),
    .valid_o(valid_o),
    .out_column_o(out_column_o),
    .column_offset_o(column_offset_o),
    .drawn_o(drawn_o),
    .new_rows_o(new_rows_o),
    .moving_o(moving_o),
    .frame_done_o(frame_done_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic melt_result_t predict_column_step(smw_pkg::action_e act,
                                                       logic [8:0] col,
                                                       logic [7:0] rnd);
    melt_result_t r;
    int p;
    int v;
    r.column = col;
    r.offset = '0;
    r.drawn = 1'b0;
    r.rows = '0;
    r.moving = 1'b0;
    r.done = 1'b0;
    if (col >= COLUMNS) return r;
    if (act == smw_pkg::ACT_SEED) begin
      if (col == 0) begin
        v = -int'(rnd & 8'd15);
      end else begin
        v = seed_prev + int'(rnd % 3) - 1;
        if (v > 0) v = 0;
        else if (v == smw_pkg::SEED_FLOOR) v = smw_pkg::SEED_FLOOR_FIX;
      end
      column_pos[col] = v;
      seeded[col] = 1'b1;
      seed_prev = v;
      r.offset = v[8:0];
      return r;
    end
    p = column_pos[col];
    if (p < 0) begin
      p++;
      r.moving = 1'b1;
    end else if (p < ROWS) begin
      p += (p < smw_pkg::FAST_LIMIT) ? p + 1 : smw_pkg::SLOW_STEP;
      r.moving = 1'b1;
      r.drawn = 1'b1;
      r.rows = 8'((p > ROWS) ? ROWS : p);
    end
    column_pos[col] = p;
    if (r.moving) pass_moved = 1'b1;
    if (col == COLUMNS - 1) begin
      r.done = !pass_moved;
      pass_moved = 1'b0;
    end
    r.offset = p[8:0];
    return r;
  endfunction

  task automatic send_item(smw_pkg::action_e act, logic [8:0] col, logic [7:0] rnd);
    int gap;
    int pick;
    start_i <= 1'b1;
    action_i <= act;
    column_i <= col;
    random_byte_i <= rnd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.push_back(predict_column_step(act, col, rnd));
    items_sent++;
    gap = 0;
    if (gaps_enabled) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) gap = $urandom_range(4, 24);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // out of range, reseed, or advance of any seeded column
  task automatic send_noise_item();
    int kind;
    int c;
    kind = $urandom_range(0, 2);
    c = $urandom_range(0, COLUMNS - 1);
    if (kind == 0) begin
      send_item(smw_pkg::action_e'($urandom_range(0, 1)), 9'($urandom_range(COLUMNS, 511)),
                8'($urandom));
    end else if (kind == 1 || !seeded[c]) begin
      send_item(smw_pkg::ACT_SEED, 9'(c), 8'($urandom));
    end else begin
      send_item(smw_pkg::ACT_ADVANCE, 9'(c), 8'($urandom));
    end
  endtask

  always @(posedge clk_i) begin
    melt_result_t want;
    if (valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result for column %0d", $time, out_column_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (drawn_o === 1'b1) drawn_seen++;
        if (frame_done_o === 1'b1) done_seen++;
        if (out_column_o !== want.column) begin
          $display("%0t: out_column expected %0d actual %0d", $time, want.column,
                   out_column_o);
          errors++;
        end
        if (column_offset_o !== want.offset) begin
          $display("%0t: column_offset col %0d expected %0d actual %0d", $time, want.column,
                   want.offset, column_offset_o);
          errors++;
        end
        if (drawn_o !== want.drawn) begin
          $display("%0t: drawn col %0d expected %0b actual %0b", $time, want.column,
                   want.drawn, drawn_o);
          errors++;
        end
        if (new_rows_o !== want.rows) begin
          $display("%0t: new_rows col %0d expected %0d actual %0d", $time, want.column,
                   want.rows, new_rows_o);
          errors++;
        end
        if (moving_o !== want.moving) begin
          $display("%0t: moving col %0d expected %0b actual %0b", $time, want.column,
                   want.moving, moving_o);
          errors++;
        end
        if (frame_done_o !== want.done) begin
          $display("%0t: frame_done col %0d expected %0b actual %0b", $time, want.column,
                   want.done, frame_done_o);
          errors++;
        end
      end
    end
  end

  task automatic test_seed_rules();
    send_item(smw_pkg::ACT_SEED, 9'd0, 8'd0);
    // positive sum capped at zero
    send_item(smw_pkg::ACT_SEED, 9'd1, 8'd2);
    send_item(smw_pkg::ACT_SEED, 9'd0, 8'd15);
    // floor raised by one
    send_item(smw_pkg::ACT_SEED, 9'd1, 8'd0);
    send_item(smw_pkg::ACT_SEED, 9'd2, 8'd255);
    send_item(smw_pkg::ACT_SEED, 9'd3, 8'd1);
    send_item(smw_pkg::ACT_SEED, 9'd318, 8'd128);
    // only the low nibble counts for column zero
    send_item(smw_pkg::ACT_SEED, 9'd0, 8'hF0);
  endtask

  task automatic test_advance_rules();
    send_item(smw_pkg::ACT_SEED, 9'd0, 8'd0);
    repeat (6) send_item(smw_pkg::ACT_ADVANCE, 9'd0, 8'($urandom));
    send_item(smw_pkg::ACT_ADVANCE, 9'd3, 8'd0);
    send_item(smw_pkg::ACT_SEED, 9'(COLUMNS - 1), 8'd2);
    send_item(smw_pkg::ACT_ADVANCE, 9'(COLUMNS - 1), 8'd0);
  endtask

  task automatic test_out_of_range();
    send_item(smw_pkg::ACT_SEED, 9'(COLUMNS), 8'd7);
    send_item(smw_pkg::ACT_ADVANCE, 9'd511, 8'd0);
    send_item(smw_pkg::ACT_SEED, 9'd400, 8'd255);
  endtask

  // seed a few columns, then advance them frame by frame until settled plus one pass
  task automatic test_melt_episode(int width);
    int cols[$];
    int rounds;
    bit settled;
    bit base_zero;
    base_zero = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < width; i++) begin
      cols.push_back(base_zero ? i : $urandom_range(1, COLUMNS - 2));
    end
    if ($urandom_range(0, 3) != 0) cols.push_back(COLUMNS - 1);
    foreach (cols[i]) send_item(smw_pkg::ACT_SEED, 9'(cols[i]), 8'($urandom));
    settled = 1'b0;
    rounds = 0;
    while (rounds < 60 && items_sent < ITEM_TARGET) begin
      foreach (cols[i]) begin
        if ($urandom_range(0, 99) < 4) send_noise_item();
        send_item(smw_pkg::ACT_ADVANCE, 9'(cols[i]), 8'($urandom));
      end
      rounds++;
      if (settled) break;
      settled = 1'b1;
      foreach (cols[i]) if (column_pos[cols[i]] < ROWS) settled = 1'b0;
    end
  endtask

  task automatic test_random_melts();
    while (items_sent < ITEM_TARGET) begin
      gaps_enabled = ($urandom_range(0, 3) != 0);
      test_melt_episode($urandom_range(1, 5));
      gaps_enabled = 1'b1;
      repeat ($urandom_range(5, 20)) send_noise_item();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_seed_rules();
    test_advance_rules();
    test_out_of_range();
    test_random_melts();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("sent %0d items, checked %0d results", items_sent, results_checked);
    $display("redrawn columns %0d, settled frames %0d", drawn_seen, done_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
src/smw_pkg.sv
src/smw_ram.sv
src/screen_melt_wipe_columns.sv
src/smw_checker.sv
verif/testbench.sv
